>>> rtl/core/tsb_pkg.sv
`default_nettype none

package tsb_pkg;

    // texel index into the texture and mask stores (row * width + column)
    localparam int IDX_W     = 12;
    localparam int PIX_W     = 32;
    localparam int COORD_W   = 32;
    localparam int LOG2_W    = 3;
    localparam int CFG_IDX_W = 3;

    // largest texture side, as log2
    localparam logic [LOG2_W-1:0] MAX_LOG2 = 3'd6;

    // command queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_U_STEP      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_V_STEP      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MASK_U_STEP = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MASK_V_STEP = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH_LOG2  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT_LOG2 = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_BLEND_MODE  = 3'd6;

    typedef enum logic [1:0] {
        MODE_LOAD_TEX  = 2'd0,
        MODE_LOAD_MASK = 2'd1,
        MODE_SPAN      = 2'd2,
        MODE_PIXEL     = 2'd3
    } t_item_mode;

    typedef enum logic [1:0] {
        BLEND_COPY       = 2'd0,
        BLEND_PREMUL     = 2'd1,
        BLEND_MASK_ALPHA = 2'd2,
        BLEND_SEPARATE   = 2'd3
    } t_blend_mode;

    typedef enum logic [1:0] {
        CMD_LOAD_TEX  = 2'd0,
        CMD_LOAD_MASK = 2'd1,
        CMD_SHADE     = 2'd2
    } t_cmd_kind;

    typedef struct packed {
        logic [COORD_W-1:0] u_step;
        logic [COORD_W-1:0] v_step;
        logic [COORD_W-1:0] mask_u_step;
        logic [COORD_W-1:0] mask_v_step;
        logic [LOG2_W-1:0]  width_log2;
        logic [LOG2_W-1:0]  height_log2;
        t_blend_mode        blend_mode;
    } t_tsb_cfg;

    // one store command: each index plus its quotient by the store depth
    typedef struct packed {
        t_cmd_kind        kind;
        logic [IDX_W-1:0] tex_idx;
        logic [IDX_W-1:0] tex_quo;
        logic [IDX_W-1:0] msk_idx;
        logic [IDX_W-1:0] msk_quo;
        logic [PIX_W-1:0] data;
    } t_tsb_cmd;

endpackage

`default_nettype wire

>>> rtl/core/tsb_front.sv
`default_nettype none

module tsb_front
    import tsb_pkg::*;
#(
    parameter int TEXEL_DEPTH = 4096
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire logic [1:0]         i_mode,
    input  wire logic [IDX_W-1:0]   i_load_index,
    input  wire logic [PIX_W-1:0]   i_load_texel,
    input  wire logic [COORD_W-1:0] i_span_u,
    input  wire logic [COORD_W-1:0] i_span_v,
    input  wire logic [COORD_W-1:0] i_span_mask_u,
    input  wire logic [COORD_W-1:0] i_span_mask_v,
    input  wire logic [PIX_W-1:0]   i_dest_pixel,
    input  wire t_tsb_cfg           i_cfg,
    input  wire logic               i_full,
    output logic                    o_push,
    output t_tsb_cmd                o_cmd
);

    // exact quotient by reciprocal for any index below 2**IDX_W
    localparam int RECIP_SH = 2 * IDX_W + 1;
    localparam int RECIP_W  = RECIP_SH + 1;
    localparam int PROD_W   = IDX_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'((2 ** RECIP_SH + TEXEL_DEPTH - 1) / TEXEL_DEPTH);

    logic [COORD_W-1:0] r_u_acc, n_u_acc;
    logic [COORD_W-1:0] r_v_acc, n_v_acc;
    logic [COORD_W-1:0] r_mu_acc, n_mu_acc;
    logic [COORD_W-1:0] r_mv_acc, n_mv_acc;

    t_item_mode        item_mode;
    logic              accept;
    logic [LOG2_W-1:0] wl;
    logic [LOG2_W-1:0] hl;
    logic [IDX_W-1:0]  tex_idx;
    logic [IDX_W-1:0]  sep_idx;
    logic [IDX_W-1:0]  msk_idx;

    function automatic logic [IDX_W-1:0] texel_idx(
        input logic [COORD_W-1:0] u,
        input logic [COORD_W-1:0] v,
        input logic [LOG2_W-1:0]  w_l2,
        input logic [LOG2_W-1:0]  h_l2
    );
        logic [5:0]       col;
        logic [5:0]       row;
        logic [IDX_W-1:0] row_sh;
        col    = u[21:16] & ~(6'h3f << w_l2);
        row    = v[21:16] & ~(6'h3f << h_l2);
        row_sh = IDX_W'(row) << w_l2;
        return row_sh + IDX_W'(col);
    endfunction

    function automatic logic [IDX_W-1:0] quotient(input logic [IDX_W-1:0] idx);
        logic [PROD_W-1:0] prod;
        prod = PROD_W'(idx) * PROD_W'(RECIP);
        return prod[RECIP_SH +: IDX_W];
    endfunction

    assign item_mode = t_item_mode'(i_mode);
    assign o_ready   = !i_full;
    assign accept    = i_valid && o_ready;

    assign wl = (i_cfg.width_log2 > MAX_LOG2) ? MAX_LOG2 : i_cfg.width_log2;
    assign hl = (i_cfg.height_log2 > MAX_LOG2) ? MAX_LOG2 : i_cfg.height_log2;

    assign tex_idx = texel_idx(r_u_acc, r_v_acc, wl, hl);
    assign sep_idx = texel_idx(r_mu_acc, r_mv_acc, wl, hl);
    assign msk_idx = (i_cfg.blend_mode == BLEND_SEPARATE) ? sep_idx : tex_idx;

    // classify the item into a store command
    always_comb begin
        o_push = 1'b0;
        o_cmd  = '0;
        unique case (item_mode)
            MODE_LOAD_TEX, MODE_LOAD_MASK: begin
                // loads beyond the store are dropped
                o_push        = accept && (int'(i_load_index) < TEXEL_DEPTH);
                o_cmd.kind    = (item_mode == MODE_LOAD_TEX) ? CMD_LOAD_TEX : CMD_LOAD_MASK;
                o_cmd.tex_idx = i_load_index;
                o_cmd.msk_idx = i_load_index;
                o_cmd.data    = i_load_texel;
            end
            MODE_PIXEL: begin
                o_push        = accept;
                o_cmd.kind    = CMD_SHADE;
                o_cmd.tex_idx = tex_idx;
                o_cmd.tex_quo = quotient(tex_idx);
                o_cmd.msk_idx = msk_idx;
                o_cmd.msk_quo = quotient(msk_idx);
                o_cmd.data    = i_dest_pixel;
            end
            default: begin
                o_push = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_u_acc  = r_u_acc;
        n_v_acc  = r_v_acc;
        n_mu_acc = r_mu_acc;
        n_mv_acc = r_mv_acc;
        if (accept && item_mode == MODE_SPAN) begin
            n_u_acc  = i_span_u;
            n_v_acc  = i_span_v;
            n_mu_acc = i_span_mask_u;
            n_mv_acc = i_span_mask_v;
        end else if (accept && item_mode == MODE_PIXEL) begin
            n_u_acc  = r_u_acc + i_cfg.u_step;
            n_v_acc  = r_v_acc + i_cfg.v_step;
            n_mu_acc = r_mu_acc + i_cfg.mask_u_step;
            n_mv_acc = r_mv_acc + i_cfg.mask_v_step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_u_acc  <= '0;
            r_v_acc  <= '0;
            r_mu_acc <= '0;
            r_mv_acc <= '0;
        end else begin
            r_u_acc  <= n_u_acc;
            r_v_acc  <= n_v_acc;
            r_mu_acc <= n_mu_acc;
            r_mv_acc <= n_mv_acc;
        end
    end

`ifndef SYNTHESIS
    a_span_loads_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && accept && item_mode == MODE_SPAN) |=>
            (r_u_acc == $past(i_span_u) && r_mv_acc == $past(i_span_mask_v)))
        else $error("span start did not load the coordinates");
`endif

endmodule

`default_nettype wire

>>> rtl/core/tsb_queue.sv
`default_nettype none

module tsb_queue
    import tsb_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_push,
    input  wire t_tsb_cmd i_cmd,
    output logic          o_full,
    output logic          o_valid,
    output t_tsb_cmd      o_cmd,
    input  wire logic     i_pop
);

    localparam logic [QPTR_W:0] FULL_COUNT = (QPTR_W + 1)'(QUEUE_DEPTH);

    t_tsb_cmd          r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [QPTR_W:0]   r_count, n_count;

    assign o_full  = (r_count == FULL_COUNT);
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("command queue written while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("command queue read while empty");

    a_count_tracks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && i_push && !i_pop) |=> (r_count == $past(r_count) + 1'b1))
        else $error("command queue count lost a push");
`endif

endmodule

`default_nettype wire

>>> rtl/core/tsb_back.sv
`default_nettype none

module tsb_back
    import tsb_pkg::*;
#(
    parameter int TEXEL_DEPTH = 4096
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cmd_valid,
    input  wire t_tsb_cmd         i_cmd,
    output logic                  o_pop,
    input  wire t_blend_mode      i_blend_mode,
    output logic                  o_valid,
    input  wire logic             i_ready,
    output logic [PIX_W-1:0]      o_out_pixel
);

    localparam int ADDR_W  = (TEXEL_DEPTH > 1) ? $clog2(TEXEL_DEPTH) : 1;
    localparam int EXT_W   = (ADDR_W > IDX_W) ? ADDR_W : IDX_W;
    localparam int DEPTH_W = $clog2(TEXEL_DEPTH + 1);
    localparam int PROD_W  = IDX_W + DEPTH_W;

    logic [PIX_W-1:0] r_tex_mem [TEXEL_DEPTH];
    logic [PIX_W-1:0] r_msk_mem [TEXEL_DEPTH];

    logic [PIX_W-1:0] r_tex_rd;
    logic [PIX_W-1:0] r_msk_rd;
    logic             r_s1_valid, n_s1_valid;
    logic [PIX_W-1:0] r_s1_dest;
    logic             r_o_valid, n_o_valid;
    logic [PIX_W-1:0] r_out_pixel;

    logic              s2_free;
    logic              s1_free;
    logic              is_shade;
    logic [ADDR_W-1:0] tex_addr;
    logic [ADDR_W-1:0] msk_addr;

    // index minus quotient times depth, the remainder
    function automatic logic [ADDR_W-1:0] store_addr(
        input logic [IDX_W-1:0] idx,
        input logic [IDX_W-1:0] quo
    );
        logic [PROD_W-1:0] prod;
        logic [IDX_W-1:0]  rem;
        logic [EXT_W-1:0]  ext;
        prod = PROD_W'(quo) * PROD_W'(TEXEL_DEPTH);
        rem  = idx - prod[IDX_W-1:0];
        ext  = EXT_W'(rem);
        return ext[ADDR_W-1:0];
    endfunction

    function automatic logic [7:0] mix_chan(
        input logic [7:0] c,
        input logic [7:0] d,
        input logic [7:0] m
    );
        logic [16:0] s;
        s = 17'(c) * 17'(m) + 17'(d) * 17'(9'd256 - 9'(m));
        return s[15:8];
    endfunction

    function automatic logic [PIX_W-1:0] blend(
        input t_blend_mode      bm,
        input logic [PIX_W-1:0] t,
        input logic [PIX_W-1:0] m,
        input logic [PIX_W-1:0] d
    );
        logic [PIX_W-1:0] res;
        logic [8:0]       inv;
        logic [15:0]      prod;
        logic [8:0]       sum;
        res  = '0;
        inv  = 9'd256 - 9'(t[31:24]);
        prod = '0;
        sum  = '0;
        unique case (bm)
            BLEND_COPY: begin
                res = t;
            end
            BLEND_PREMUL: begin
                for (int k = 0; k < 4; k++) begin
                    prod = 16'(d[8*k +: 8]) * 16'(inv);
                    sum  = 9'(t[8*k +: 8]) + 9'(prod[15:8]);
                    res[8*k +: 8] = sum[8] ? 8'hff : sum[7:0];
                end
            end
            BLEND_MASK_ALPHA: begin
                for (int k = 0; k < 3; k++) begin
                    res[8*k +: 8] = mix_chan(t[8*k +: 8], d[8*k +: 8], m[31:24]);
                end
                res[31:24] = d[31:24];
            end
            default: begin
                for (int k = 0; k < 3; k++) begin
                    res[8*k +: 8] = mix_chan(t[8*k +: 8], d[8*k +: 8], m[8*k +: 8]);
                end
                res[31:24] = d[31:24];
            end
        endcase
        return res;
    endfunction

    assign s2_free  = !r_o_valid || i_ready;
    assign s1_free  = !r_s1_valid || s2_free;
    assign is_shade = (i_cmd.kind == CMD_SHADE);
    assign o_pop    = i_cmd_valid && (!is_shade || s1_free);
    assign tex_addr = store_addr(i_cmd.tex_idx, i_cmd.tex_quo);
    assign msk_addr = store_addr(i_cmd.msk_idx, i_cmd.msk_quo);

    always_ff @(posedge i_clk) begin
        if (o_pop && i_cmd.kind == CMD_LOAD_TEX) begin
            r_tex_mem[tex_addr] <= i_cmd.data;
        end
        if (o_pop && is_shade) begin
            r_tex_rd <= r_tex_mem[tex_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && i_cmd.kind == CMD_LOAD_MASK) begin
            r_msk_mem[msk_addr] <= i_cmd.data;
        end
        if (o_pop && is_shade) begin
            r_msk_rd <= r_msk_mem[msk_addr];
        end
    end

    always_comb begin
        n_s1_valid = (o_pop && is_shade) || (r_s1_valid && !s2_free);
        n_o_valid  = (r_s1_valid && s2_free) || (r_o_valid && !i_ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            r_s1_valid <= n_s1_valid;
            r_o_valid  <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && is_shade) begin
            r_s1_dest <= i_cmd.data;
        end
        if (r_s1_valid && s2_free) begin
            r_out_pixel <= blend(i_blend_mode, r_tex_rd, r_msk_rd, r_s1_dest);
        end
    end

    assign o_valid     = r_o_valid;
    assign o_out_pixel = r_out_pixel;

`ifndef SYNTHESIS
    a_s1_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && r_s1_valid && !s2_free) |=> r_s1_valid)
        else $error("fetched texel dropped while output stalled");
`endif

endmodule

`default_nettype wire

>>> rtl/core/textured_span_blend_rgba_unit.sv
`default_nettype none

// textured span engine with alpha blending, 32-bit bgra (blue in the low byte)
// input channel (i_valid / o_ready): one item per transfer, i_mode selects
//   texture texel load, mask texel load, span start or shade pixel
// output channel (o_valid / i_ready): one o_out_pixel per shade-pixel item,
//   in item order; loads and span starts produce nothing
// config channel (i_cfg_valid / o_cfg_ready): always ready, i_cfg_index picks
//   the register, write only while the engine is drained
// a shade pixel passes the command queue write, the store read into a register
//   and the blend into the output register; sustained rate is one item per
//   cycle while the receiver keeps i_ready high, set by the single read port
//   on each store
// front tracks the 16.16 coordinates and turns items into store commands,
//   a four-entry command queue decouples it from the back end, which does
//   loads and fetches in order and blends
// reset clears coordinates, queue and pipeline, sets steps to one texel in u,
//   64x64 size, copy mode; store contents stay undefined until loaded
// a stalled receiver holds the output register; the back end fills behind
//   it, then the queue, and o_ready drops once the queue is full
module textured_span_blend_rgba_unit
    import tsb_pkg::*;
#(
    parameter int TEXEL_DEPTH = 4096
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // item channel
    input  wire logic                 i_valid,
    output logic                      o_ready,
    input  wire logic [1:0]           i_mode,
    input  wire logic [IDX_W-1:0]     i_load_index,
    input  wire logic [PIX_W-1:0]     i_load_texel,
    input  wire logic [COORD_W-1:0]   i_span_u,
    input  wire logic [COORD_W-1:0]   i_span_v,
    input  wire logic [COORD_W-1:0]   i_span_mask_u,
    input  wire logic [COORD_W-1:0]   i_span_mask_v,
    input  wire logic [PIX_W-1:0]     i_dest_pixel,
    // result channel
    output logic                      o_valid,
    input  wire logic                 i_ready,
    output logic [PIX_W-1:0]          o_out_pixel,
    // config channel
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [COORD_W-1:0]   i_cfg_data
);

    t_tsb_cfg r_cfg, n_cfg;

    logic     q_push;
    t_tsb_cmd q_in_cmd;
    logic     q_full;
    logic     q_valid;
    t_tsb_cmd q_out_cmd;
    logic     q_pop;

    // register file writes, unknown indexes are ignored
    assign o_cfg_ready = 1'b1;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_U_STEP:      n_cfg.u_step      = i_cfg_data;
                CFG_V_STEP:      n_cfg.v_step      = i_cfg_data;
                CFG_MASK_U_STEP: n_cfg.mask_u_step = i_cfg_data;
                CFG_MASK_V_STEP: n_cfg.mask_v_step = i_cfg_data;
                CFG_WIDTH_LOG2:  n_cfg.width_log2  = i_cfg_data[LOG2_W-1:0];
                CFG_HEIGHT_LOG2: n_cfg.height_log2 = i_cfg_data[LOG2_W-1:0];
                CFG_BLEND_MODE:  n_cfg.blend_mode  = t_blend_mode'(i_cfg_data[1:0]);
                default:         n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.u_step      <= 32'h0001_0000;
            r_cfg.v_step      <= '0;
            r_cfg.mask_u_step <= 32'h0001_0000;
            r_cfg.mask_v_step <= '0;
            r_cfg.width_log2  <= MAX_LOG2;
            r_cfg.height_log2 <= MAX_LOG2;
            r_cfg.blend_mode  <= BLEND_COPY;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    // coordinate tracking and item classification
    tsb_front #(
        .TEXEL_DEPTH (TEXEL_DEPTH)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_mode        (i_mode),
        .i_load_index  (i_load_index),
        .i_load_texel  (i_load_texel),
        .i_span_u      (i_span_u),
        .i_span_v      (i_span_v),
        .i_span_mask_u (i_span_mask_u),
        .i_span_mask_v (i_span_mask_v),
        .i_dest_pixel  (i_dest_pixel),
        .i_cfg         (r_cfg),
        .i_full        (q_full),
        .o_push        (q_push),
        .o_cmd         (q_in_cmd)
    );

    // keeps loads and fetches in item order
    tsb_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (q_in_cmd),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_cmd   (q_out_cmd),
        .i_pop   (q_pop)
    );

    // store access, blend and output register
    tsb_back #(
        .TEXEL_DEPTH (TEXEL_DEPTH)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd_valid  (q_valid),
        .i_cmd        (q_out_cmd),
        .o_pop        (q_pop),
        .i_blend_mode (r_cfg.blend_mode),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_out_pixel  (o_out_pixel)
    );

endmodule

`default_nettype wire
